/* design/qpd_pkg.sv */
// Shared constants and the command word type of the quoted-printable decoder.
`default_nettype none
package qpd_pkg;

    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;

    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            count;
        logic                        empty;
        logic                        last;
    } cmd_t;

endpackage
`default_nettype wire

/* design/qpd_front.sv */
// Front end: escape state machine that turns each input byte into at most one command word.
`default_nettype none
module qpd_front
    import qpd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    input  wire logic       is_last,
    output logic            push,
    output cmd_t            cmd
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_EQ   = 2'd1;
    localparam logic [1:0] PH_HEX  = 2'd2;
    localparam logic [1:0] PH_CR   = 2'd3;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] held_reg, held_next;

    logic       is_hex;
    logic [3:0] hex_val;
    logic [1:0] pre_cnt;
    logic [7:0] pre0, pre1;
    logic       do_fresh;
    logic       fresh_emit;
    logic [CNT_W-1:0] total;

    always_comb begin
        is_hex  = 1'b0;
        hex_val = 4'd0;
        if (in_byte >= CHAR_ZERO && in_byte <= CHAR_NINE) begin
            is_hex  = 1'b1;
            hex_val = 4'(in_byte - CHAR_ZERO);
        end else if (in_byte >= CHAR_UA && in_byte <= CHAR_UF) begin
            is_hex  = 1'b1;
            hex_val = 4'(in_byte - CHAR_UA + 8'd10);
        end
    end

    always_comb begin
        pre_cnt    = 2'd0;
        pre0       = in_byte;
        pre1       = in_byte;
        do_fresh   = 1'b0;
        phase_next = PH_IDLE;
        held_next  = held_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                do_fresh = 1'b1;
            end
            PH_EQ: begin
                if (is_last) begin
                    do_fresh = 1'b1;
                end else if (in_byte == CHAR_CR) begin
                    phase_next = PH_CR;
                end else if (is_hex) begin
                    held_next  = hex_val;
                    phase_next = PH_HEX;
                end else begin
                    pre_cnt = 2'd2;
                    pre0    = CHAR_EQ;
                    pre1    = in_byte;
                end
            end
            PH_HEX: begin
                pre_cnt = 2'd1;
                if (is_hex) begin
                    pre0 = {held_reg, hex_val};
                end else begin
                    pre0     = {held_reg, 4'd0};
                    do_fresh = 1'b1;
                end
            end
            PH_CR: begin
                if (in_byte != CHAR_LF) begin
                    pre_cnt  = 2'd2;
                    pre0     = CHAR_EQ;
                    pre1     = CHAR_CR;
                    do_fresh = 1'b1;
                end
            end
            default: begin
                do_fresh = 1'b1;
            end
        endcase
        fresh_emit = do_fresh && (in_byte != CHAR_EQ);
        if (do_fresh && in_byte == CHAR_EQ && !is_last) begin
            phase_next = PH_EQ;
        end
        if (is_last) begin
            phase_next = PH_IDLE;
            held_next  = 4'd0;
        end
    end

    always_comb begin
        total        = CNT_W'(pre_cnt) + CNT_W'(fresh_emit);
        cmd.bytes[0] = (pre_cnt > 2'd0) ? pre0 : in_byte;
        cmd.bytes[1] = (pre_cnt > 2'd1) ? pre1 : in_byte;
        cmd.bytes[2] = in_byte;
        cmd.last     = is_last;
        cmd.empty    = (total == '0);
        cmd.count    = (total == '0) ? CNT_W'(1) : total;
        push         = accept && ((total != '0) || is_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            held_reg  <= 4'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule
`default_nettype wire

/* design/qpd_queue.sv */
// Short queue of command words between the front and back ends.
`default_nettype none
module qpd_queue
    import qpd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output logic      not_empty,
    output logic      not_full
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign not_full  = (cnt_reg != QCNT_W'(QUEUE_DEPTH));

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

/* design/qpd_back.sv */
// Back end: expands each command word into result words through an output register.
`default_nettype none
module qpd_back
    import qpd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cmd_t head,
    input  wire logic head_valid,
    output logic      pop,
    output logic       m_valid,
    input  wire logic  m_ready,
    output logic [7:0] m_byte,
    output logic       m_byte_valid,
    output logic       m_run_last,
    output logic       m_stream_end
);

    logic [CNT_W-1:0] idx_reg;
    logic             valid_reg;
    logic [7:0]       byte_reg;
    logic             bvalid_reg, rlast_reg, send_reg;
    logic             load;
    logic             at_end;

    assign load   = head_valid && (!valid_reg || m_ready);
    assign at_end = (idx_reg == head.count - CNT_W'(1));
    assign pop    = load && at_end;

    assign m_valid      = valid_reg;
    assign m_byte       = byte_reg;
    assign m_byte_valid = bvalid_reg;
    assign m_run_last   = rlast_reg;
    assign m_stream_end = send_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg   <= head.empty ? 8'd0 : head.bytes[idx_reg[1:0]];
            bvalid_reg <= !head.empty;
            rlast_reg  <= at_end;
            send_reg   <= at_end && head.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= at_end ? '0 : idx_reg + CNT_W'(1);
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

/* design/quoted_printable_decoder_core.sv */
// Quoted-printable decoder top level: front end, command queue and back end.
//
// Usage:
//   Encoded bytes enter on the s_axis channel, one word per handshake, with
//   s_axis_tlast marking the final byte of the encoded stream. Decoded bytes
//   leave on the m_axis channel; m_axis_tlast marks the last result word caused
//   by one input word, m_axis_tuser[1] the final word of the stream, and
//   m_axis_tuser[0] clear marks the empty end word of a stream whose final
//   input gave no byte. Soft line breaks and held escape bytes give no word.
//   Throughput: one input word per cycle while the queue has room and one result
//   word per cycle while m_axis_tready is high; an input word that expands to two
//   or three results is absorbed by a four-entry command queue.
//   Each accepted word passes through the command queue and the output register.
//   Reset clears the escape state, the queue and the output valid flag.
//   When the receiver stalls, the output word holds; input keeps being taken
//   until the command queue fills, then s_axis_tready drops.
`default_nettype none
module quoted_printable_decoder_core
    import qpd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]      m_axis_tuser,   // [0] byte_valid, [1] stream_end
    output logic            m_axis_tlast
);

    cmd_t front_cmd, head_cmd;
    logic accept, push, pop, q_not_empty, q_not_full;
    logic bvalid, send;

    assign s_axis_tready = q_not_full;
    assign accept        = s_axis_tvalid && q_not_full;
    assign m_axis_tuser  = {send, bvalid};

    qpd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_axis_tdata),
        .is_last (s_axis_tlast),
        .push    (push),
        .cmd     (front_cmd)
    );

    qpd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (front_cmd),
        .pop       (pop),
        .head      (head_cmd),
        .not_empty (q_not_empty),
        .not_full  (q_not_full)
    );

    qpd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head_cmd),
        .head_valid   (q_not_empty),
        .pop          (pop),
        .m_valid      (m_axis_tvalid),
        .m_ready      (m_axis_tready),
        .m_byte       (m_axis_tdata),
        .m_byte_valid (bvalid),
        .m_run_last   (m_axis_tlast),
        .m_stream_end (send)
    );

endmodule
`default_nettype wire

/* bench/tb_quoted_printable_decoder_core.sv */
// Self-checking testbench of the quoted-printable decoder core: stream driver, monitor, predictor.
`timescale 1ns / 1ps
module tb_quoted_printable_decoder_core;
    import qpd_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_EQ, PH_DIGIT, PH_CR} esc_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } enc_word_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       run_last;
        logic       stream_end;
    } dec_word_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;

    enc_word_t  enc_q[$];
    dec_word_t  decoded_q[$];
    esc_phase_t esc_phase = PH_IDLE;
    logic [3:0] held_nib = 4'h0;
    logic       in_fire = 1'b0;
    int         tx_idle_pct = 19;
    int         rx_idle_pct = 65;
    int         hold_left = 0;
    logic       hold_req = 1'b0;
    int         err_count = 0;
    int         words_added = 0;

    quoted_printable_decoder_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] in_byte
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte
        .m_axis_tuser  (m_axis_tuser),   // [0] byte_valid, [1] stream_end
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        err_count++;
    endtask

    function automatic logic [4:0] hex_lookup(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            return {1'b1, 4'(c - CHAR_ZERO)};
        if (c >= CHAR_UA && c <= CHAR_UF)
            return {1'b1, 4'(c - CHAR_UA + 8'd10)};
        return 5'b0;
    endfunction

    function automatic logic [7:0] hex_char(input int d);
        return (d < 10) ? 8'(CHAR_ZERO + d) : 8'(CHAR_UA + d - 10);
    endfunction

    task automatic put_byte(input logic [7:0] b);
        decoded_q.push_back('{b, 1'b1, 1'b0, 1'b0});
    endtask

    task automatic take_fresh(input logic [7:0] c, input logic last);
        if (c == CHAR_EQ) begin
            esc_phase = last ? PH_IDLE : PH_EQ;
        end else begin
            put_byte(c);
            esc_phase = PH_IDLE;
        end
    endtask

    task automatic decode_word(input logic [7:0] c, input logic last);
        logic [4:0] hx;
        int         base;
        base = decoded_q.size();
        hx = hex_lookup(c);
        case (esc_phase)
            PH_IDLE: begin
                take_fresh(c, last);
            end
            PH_EQ: begin
                if (last) begin
                    take_fresh(c, 1'b1);
                end else if (c == CHAR_CR) begin
                    esc_phase = PH_CR;
                end else if (hx[4]) begin
                    held_nib = hx[3:0];
                    esc_phase = PH_DIGIT;
                end else begin
                    put_byte(CHAR_EQ);
                    put_byte(c);
                    esc_phase = PH_IDLE;
                end
            end
            PH_DIGIT: begin
                if (hx[4]) begin
                    put_byte({held_nib, hx[3:0]});
                    esc_phase = PH_IDLE;
                end else begin
                    put_byte({held_nib, 4'h0});
                    take_fresh(c, last);
                end
            end
            default: begin
                if (c == CHAR_LF) begin
                    esc_phase = PH_IDLE;
                end else begin
                    put_byte(CHAR_EQ);
                    put_byte(CHAR_CR);
                    take_fresh(c, last);
                end
            end
        endcase
        if (last) begin
            if (decoded_q.size() == base)
                decoded_q.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
            decoded_q[decoded_q.size() - 1].stream_end = 1'b1;
            esc_phase = PH_IDLE;
            held_nib = 4'h0;
        end
        if (decoded_q.size() > base)
            decoded_q[decoded_q.size() - 1].run_last = 1'b1;
    endtask

    task automatic check_word();
        dec_word_t want;
        if (decoded_q.size() == 0) begin
            flag_error($sformatf("unexpected word data=%02h user=%b last=%b",
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast));
            return;
        end
        want = decoded_q.pop_front();
        if (m_axis_tdata !== want.data)
            flag_error($sformatf("out_byte %02h, want %02h", m_axis_tdata, want.data));
        if (m_axis_tuser[0] !== want.valid)
            flag_error($sformatf("byte_valid %b, want %b", m_axis_tuser[0], want.valid));
        if (m_axis_tlast !== want.run_last)
            flag_error($sformatf("run_last %b, want %b", m_axis_tlast, want.run_last));
        if (m_axis_tuser[1] !== want.stream_end)
            flag_error($sformatf("stream_end %b, want %b", m_axis_tuser[1], want.stream_end));
    endtask

    // sample both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            in_fire = s_axis_tvalid && s_axis_tready;
            if (in_fire) begin
                decode_word(enc_q[0].data, enc_q[0].last);
                void'(enc_q.pop_front());
            end
            if (m_axis_tvalid && m_axis_tready)
                check_word();
        end else begin
            in_fire = 1'b0;
        end
    end

    // hold the offered word until taken, then advance
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (enc_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= enc_q[0].data;
                s_axis_tlast  <= enc_q[0].last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req      <= 1'b0;
            hold_left     <= 300;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic add_word(input logic [7:0] c, input logic last);
        enc_q.push_back('{c, last});
        words_added++;
    endtask

    task automatic add_stream();
        logic [7:0] chars[$];
        int         n_tok;
        int         i;
        n_tok = $urandom_range(1, 8);
        repeat (n_tok) begin
            case ($urandom_range(0, 11))
                0, 1, 2: chars.push_back(8'($urandom_range(8'h20, 8'h7E)));
                3, 4, 5: begin
                    chars.push_back(CHAR_EQ);
                    chars.push_back(hex_char($urandom_range(0, 15)));
                    chars.push_back(hex_char($urandom_range(0, 15)));
                end
                6: begin
                    chars.push_back(CHAR_EQ);
                    chars.push_back(CHAR_CR);
                    chars.push_back(CHAR_LF);
                end
                7: chars.push_back(8'($urandom_range(0, 255)));
                8: begin
                    chars.push_back(CHAR_EQ);
                    chars.push_back(hex_char($urandom_range(0, 15)));
                    chars.push_back(8'($urandom_range(0, 255)));
                end
                9: begin
                    chars.push_back(CHAR_EQ);
                    chars.push_back(8'($urandom_range(0, 255)));
                end
                10: begin
                    chars.push_back(CHAR_EQ);
                    chars.push_back(CHAR_CR);
                    chars.push_back(8'($urandom_range(0, 255)));
                end
                default: chars.push_back(CHAR_EQ);
            endcase
        end
        for (i = 0; i < chars.size(); i++)
            add_word(chars[i], i == chars.size() - 1);
    endtask

    task automatic wait_drained();
        while (enc_q.size() != 0 || decoded_q.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        add_word(8'h00, 1'b0);
        add_word(8'hFF, 1'b0);
        add_word(CHAR_EQ, 1'b0);
        add_word("3", 1'b0);
        add_word("D", 1'b0);
        add_word(CHAR_EQ, 1'b0);
        add_word(CHAR_UF, 1'b0);
        add_word(CHAR_ZERO, 1'b0);
        add_word(CHAR_EQ, 1'b0);
        add_word(CHAR_CR, 1'b0);
        add_word(CHAR_LF, 1'b0);
        add_word(CHAR_EQ, 1'b0);
        add_word(CHAR_UA, 1'b0);
        add_word("x", 1'b0);
        add_word(CHAR_EQ, 1'b0);
        add_word("a", 1'b0);
        add_word(CHAR_EQ, 1'b0);
        add_word(CHAR_CR, 1'b0);
        add_word("q", 1'b0);
        add_word(CHAR_EQ, 1'b0);
        add_word(CHAR_NINE, 1'b1);
        add_word("Z", 1'b0);
        add_word(CHAR_EQ, 1'b1);
        add_word(CHAR_EQ, 1'b1);
        while (words_added < 65)
            add_stream();
        wait_drained();

        tx_idle_pct = 65;
        rx_idle_pct = 19;
        while (words_added < 105)
            add_stream();
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
        while (words_added < 145)
            add_stream();
        wait_drained();

        repeat (20) @(posedge aclk);
        if (decoded_q.size() != 0)
            flag_error($sformatf("%0d expected words never arrived", decoded_q.size()));
        if (err_count == 0) begin
            $display("tb_quoted_printable_decoder_core: clean");
        end else begin
            $display("tb_quoted_printable_decoder_core: errors");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("tb_quoted_printable_decoder_core: errors");
        $finish;
    end

endmodule

/* filelist.f */
design/qpd_pkg.sv
design/qpd_front.sv
design/qpd_queue.sv
design/qpd_back.sv
design/quoted_printable_decoder_core.sv
bench/tb_quoted_printable_decoder_core.sv
